/* hw/rtl/aggregation_automaton_cell_update_core_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the aggregation automaton cell update core
// Clocked implication checks, reset-qualified, reporting through $error.
// ----------------------------------------------------------------------------
`ifndef AGGREGATION_AUTOMATON_CELL_UPDATE_CORE_MACROS_SVH
`define AGGREGATION_AUTOMATON_CELL_UPDATE_CORE_MACROS_SVH

// same-cycle implication
`define AACU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// next-cycle implication
`define AACU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

/* hw/rtl/aacu_pkg.sv */
// ----------------------------------------------------------------------------
// aacu_pkg
// Shared types, codes and helper functions of the cell update core.
// ----------------------------------------------------------------------------
`default_nettype none

package aacu_pkg;

    // cell codes
    localparam logic [1:0] CELL_EMPTY = 2'd0;
    localparam logic [1:0] CELL_ICE   = 2'd1;
    localparam logic [1:0] CELL_GAS   = 2'd2;

    // operation kinds (anything else reads)
    localparam logic [1:0] KIND_LOAD   = 2'd0;
    localparam logic [1:0] KIND_UPDATE = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;

    // move directions, also bit positions of the free-neighbor mask
    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  row;
        logic [7:0]  col;
        logic [1:0]  load_value;
        logic [15:0] random_pick;
    } t_in;

    typedef struct packed {
        logic [1:0] cell_state;
        logic       froze;
        logic       moved;
        logic [1:0] move_dir;
    } t_out;

    // microprogram addresses
    typedef logic [3:0] t_step;
    localparam t_step STEP_FETCH    = 4'd0;
    localparam t_step STEP_DISP     = 4'd1;
    localparam t_step STEP_LOAD     = 4'd2;
    localparam t_step STEP_LOAD_RD  = 4'd3;
    localparam t_step STEP_READ_CAP = 4'd4;
    localparam t_step STEP_UPD_RDU  = 4'd5;
    localparam t_step STEP_UPD_RDD  = 4'd6;
    localparam t_step STEP_UPD_RDL  = 4'd7;
    localparam t_step STEP_UPD_RDR  = 4'd8;
    localparam t_step STEP_UPD_EVAL = 4'd9;
    localparam t_step STEP_UPD_FRZ  = 4'd10;
    localparam t_step STEP_UPD_MVS  = 4'd11;
    localparam t_step STEP_UPD_MVD  = 4'd12;
    localparam t_step STEP_EMIT     = 4'd13;

    typedef enum logic [2:0] {
        ASEL_C, ASEL_U, ASEL_D, ASEL_L, ASEL_R, ASEL_MOVE
    } t_asel;

    typedef enum logic [1:0] {
        WSEL_LOAD, WSEL_ICE, WSEL_EMPTY, WSEL_GAS
    } t_wsel;

    typedef enum logic [2:0] {
        CAP_NONE, CAP_C, CAP_U, CAP_D, CAP_L
    } t_cap;

    typedef enum logic [2:0] {
        JMP_NEXT, JMP_GOTO, JMP_WAIT_IN, JMP_DISPATCH, JMP_EVAL, JMP_EMIT
    } t_jump;

    typedef struct packed {
        t_asel asel;
        logic  we;
        t_wsel wsel;
        t_cap  cap;
        logic  eval;
        t_jump jump;
        t_step target;
    } t_uword;

    // sequencer -> datapath
    typedef struct packed {
        t_uword uw;
        logic   accept;
        logic   out_load;
    } t_dp_ctl;

    // datapath -> sequencer (branch conditions)
    typedef struct packed {
        logic bad_addr;
        logic is_load;
        logic is_update;
        logic freeze;
        logic move;
    } t_dp_stat;

    // v mod 3: base-4 digits each weigh 1 mod 3
    function automatic logic [1:0] mod3_16(input logic [15:0] v);
        logic [4:0] s;
        logic [2:0] t;
        s = '0;
        for (int i = 0; i < 8; i++) begin
            s = s + 5'(v[2*i +: 2]);
        end
        t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
        if (t >= 3'd6) begin
            t = t - 3'd6;
        end else if (t >= 3'd3) begin
            t = t - 3'd3;
        end
        return t[1:0];
    endfunction

    // direction of the idx-th set bit, scanning up, down, left, right
    function automatic logic [1:0] pick_dir(input logic [3:0] mask, input logic [1:0] idx);
        logic [1:0] seen;
        logic [1:0] dir;
        logic       found;
        seen  = '0;
        dir   = DIR_UP;
        found = 1'b0;
        for (int i = 0; i < 4; i++) begin
            if (mask[i]) begin
                if (!found && seen == idx) begin
                    dir   = 2'(i);
                    found = 1'b1;
                end
                seen = seen + 2'd1;
            end
        end
        return dir;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/aacu_seq.sv */
// ----------------------------------------------------------------------------
// aacu_seq
// Step counter and microcode ROM; owns both handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module aacu_seq (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    input  aacu_pkg::t_dp_stat  i_stat,
    output aacu_pkg::t_dp_ctl   o_ctl
);

    aacu_pkg::t_step  r_step;
    aacu_pkg::t_step  n_step;
    logic             r_out_valid;
    logic             n_out_valid;
    aacu_pkg::t_uword uw;
    logic             slot_free;
    logic             accept;
    logic             out_load;

    // microcode ROM
    always_comb begin
        uw = '{asel: aacu_pkg::ASEL_C, we: 1'b0, wsel: aacu_pkg::WSEL_LOAD,
               cap: aacu_pkg::CAP_NONE, eval: 1'b0, jump: aacu_pkg::JMP_NEXT,
               target: aacu_pkg::STEP_FETCH};
        case (r_step)
            aacu_pkg::STEP_FETCH: begin
                uw.jump = aacu_pkg::JMP_WAIT_IN;
            end
            aacu_pkg::STEP_DISP: begin
                uw.jump = aacu_pkg::JMP_DISPATCH;
            end
            aacu_pkg::STEP_LOAD: begin
                uw.we   = 1'b1;
                uw.wsel = aacu_pkg::WSEL_LOAD;
            end
            aacu_pkg::STEP_LOAD_RD: begin
                uw.jump = aacu_pkg::JMP_NEXT;
            end
            aacu_pkg::STEP_READ_CAP: begin
                uw.cap    = aacu_pkg::CAP_C;
                uw.jump   = aacu_pkg::JMP_GOTO;
                uw.target = aacu_pkg::STEP_EMIT;
            end
            aacu_pkg::STEP_UPD_RDU: begin
                uw.asel = aacu_pkg::ASEL_U;
                uw.cap  = aacu_pkg::CAP_C;
            end
            aacu_pkg::STEP_UPD_RDD: begin
                uw.asel = aacu_pkg::ASEL_D;
                uw.cap  = aacu_pkg::CAP_U;
            end
            aacu_pkg::STEP_UPD_RDL: begin
                uw.asel = aacu_pkg::ASEL_L;
                uw.cap  = aacu_pkg::CAP_D;
            end
            aacu_pkg::STEP_UPD_RDR: begin
                uw.asel = aacu_pkg::ASEL_R;
                uw.cap  = aacu_pkg::CAP_L;
            end
            aacu_pkg::STEP_UPD_EVAL: begin
                uw.eval = 1'b1;
                uw.jump = aacu_pkg::JMP_EVAL;
            end
            aacu_pkg::STEP_UPD_FRZ: begin
                uw.we     = 1'b1;
                uw.wsel   = aacu_pkg::WSEL_ICE;
                uw.jump   = aacu_pkg::JMP_GOTO;
                uw.target = aacu_pkg::STEP_EMIT;
            end
            aacu_pkg::STEP_UPD_MVS: begin
                uw.we   = 1'b1;
                uw.wsel = aacu_pkg::WSEL_EMPTY;
            end
            aacu_pkg::STEP_UPD_MVD: begin
                uw.asel = aacu_pkg::ASEL_MOVE;
                uw.we   = 1'b1;
                uw.wsel = aacu_pkg::WSEL_GAS;
            end
            aacu_pkg::STEP_EMIT: begin
                uw.jump = aacu_pkg::JMP_EMIT;
            end
            default: begin
                uw.jump   = aacu_pkg::JMP_GOTO;
                uw.target = aacu_pkg::STEP_FETCH;
            end
        endcase
    end

    assign slot_free = !r_out_valid || i_out_ready;
    assign accept    = i_in_valid && (uw.jump == aacu_pkg::JMP_WAIT_IN);
    assign out_load  = (uw.jump == aacu_pkg::JMP_EMIT) && slot_free;

    // next step
    always_comb begin
        case (uw.jump)
            aacu_pkg::JMP_NEXT:    n_step = r_step + 4'd1;
            aacu_pkg::JMP_GOTO:    n_step = uw.target;
            aacu_pkg::JMP_WAIT_IN: n_step = i_in_valid ? aacu_pkg::STEP_DISP
                                                       : aacu_pkg::STEP_FETCH;
            aacu_pkg::JMP_DISPATCH: begin
                if (i_stat.bad_addr) begin
                    n_step = aacu_pkg::STEP_EMIT;
                end else if (i_stat.is_load) begin
                    n_step = aacu_pkg::STEP_LOAD;
                end else if (i_stat.is_update) begin
                    n_step = aacu_pkg::STEP_UPD_RDU;
                end else begin
                    n_step = aacu_pkg::STEP_READ_CAP;
                end
            end
            aacu_pkg::JMP_EVAL: begin
                if (i_stat.freeze) begin
                    n_step = aacu_pkg::STEP_UPD_FRZ;
                end else if (i_stat.move) begin
                    n_step = aacu_pkg::STEP_UPD_MVS;
                end else begin
                    n_step = aacu_pkg::STEP_EMIT;
                end
            end
            aacu_pkg::JMP_EMIT:    n_step = slot_free ? aacu_pkg::STEP_FETCH
                                                      : aacu_pkg::STEP_EMIT;
            default:               n_step = aacu_pkg::STEP_FETCH;
        endcase
    end

    // output slot occupancy
    always_comb begin
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= aacu_pkg::STEP_FETCH;
            r_out_valid <= 1'b0;
        end else begin
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (uw.jump == aacu_pkg::JMP_WAIT_IN);
    assign o_out_valid = r_out_valid;
    assign o_ctl       = '{uw: uw, accept: accept, out_load: out_load};

endmodule

`default_nettype wire

/* hw/rtl/aacu_dpath.sv */
// ----------------------------------------------------------------------------
// aacu_dpath
// Grid memory, neighbor capture registers, update decision, result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module aacu_dpath #(
    parameter int GRID_DIM = 256
) (
    input  wire                 i_clk,
    input  aacu_pkg::t_in       i_in,
    input  aacu_pkg::t_dp_ctl   i_ctl,
    output aacu_pkg::t_dp_stat  o_stat,
    output aacu_pkg::t_out      o_out
);

    localparam int             CELLS    = GRID_DIM * GRID_DIM;
    localparam int             AW       = $clog2(CELLS);
    localparam logic [31:0]    DIM      = 32'(GRID_DIM);
    localparam logic [AW-1:0]  ROW_STEP = AW'(GRID_DIM);
    localparam logic [AW-1:0]  COL_STEP = AW'(1);

    typedef struct packed {
        logic bad;
        logic up_ok;
        logic dn_ok;
        logic lf_ok;
        logic rt_ok;
        logic lf2_ok;
        logic rt2_ok;
    } t_nbr;

    logic [1:0]     r_grid [CELLS];
    logic [1:0]     r_rdata;
    logic [AW-1:0]  r_addr_c;
    t_nbr           r_nbr;
    t_nbr           in_nbr;
    logic [1:0]     r_kind;
    logic [1:0]     r_lv;
    logic [1:0]     r_pick_lo;
    logic [1:0]     r_pick_m3;
    logic [1:0]     r_c;
    logic [1:0]     r_u;
    logic [1:0]     r_d;
    logic [1:0]     r_l;
    aacu_pkg::t_out r_res;
    aacu_pkg::t_out r_out;

    logic [31:0]    row_w;
    logic [31:0]    col_w;
    logic [AW-1:0]  mem_addr;
    logic           mem_we;
    logic [1:0]     wdata;
    logic [1:0]     right;
    logic           ice_hit;
    logic [3:0]     free_mask;
    logic [2:0]     free_cnt;
    logic [1:0]     pick_idx;
    logic [1:0]     dir;
    logic           is_gas;

    // boundary flags of the incoming address
    assign row_w = 32'(i_in.row);
    assign col_w = 32'(i_in.col);
    always_comb begin
        in_nbr.bad    = (row_w >= DIM) || (col_w >= DIM);
        in_nbr.up_ok  = (row_w != 32'd0);
        in_nbr.dn_ok  = (row_w + 32'd1 < DIM);
        in_nbr.lf_ok  = (col_w != 32'd0);
        in_nbr.rt_ok  = (col_w + 32'd1 < DIM);
        in_nbr.lf2_ok = (col_w >= 32'd2);
        in_nbr.rt2_ok = (col_w + 32'd2 < DIM);
    end

    // address select; off-grid neighbors fall back to the center cell
    always_comb begin
        case (i_ctl.uw.asel)
            aacu_pkg::ASEL_C: mem_addr = r_addr_c;
            aacu_pkg::ASEL_U: mem_addr = r_nbr.up_ok ? r_addr_c - ROW_STEP : r_addr_c;
            aacu_pkg::ASEL_D: mem_addr = r_nbr.dn_ok ? r_addr_c + ROW_STEP : r_addr_c;
            aacu_pkg::ASEL_L: mem_addr = r_nbr.lf_ok ? r_addr_c - COL_STEP : r_addr_c;
            aacu_pkg::ASEL_R: mem_addr = r_nbr.rt_ok ? r_addr_c + COL_STEP : r_addr_c;
            aacu_pkg::ASEL_MOVE: begin
                case (r_res.move_dir)
                    aacu_pkg::DIR_UP:   mem_addr = r_addr_c - ROW_STEP;
                    aacu_pkg::DIR_DOWN: mem_addr = r_addr_c + ROW_STEP;
                    aacu_pkg::DIR_LEFT: mem_addr = r_addr_c - COL_STEP;
                    default:            mem_addr = r_addr_c + COL_STEP;
                endcase
            end
            default: mem_addr = r_addr_c;
        endcase
    end

    always_comb begin
        case (i_ctl.uw.wsel)
            aacu_pkg::WSEL_LOAD:  wdata = r_lv;
            aacu_pkg::WSEL_ICE:   wdata = aacu_pkg::CELL_ICE;
            aacu_pkg::WSEL_EMPTY: wdata = aacu_pkg::CELL_EMPTY;
            default:              wdata = aacu_pkg::CELL_GAS;
        endcase
    end

    // a load of the unused code leaves the cell alone
    assign mem_we = i_ctl.uw.we &&
                    !((i_ctl.uw.wsel == aacu_pkg::WSEL_LOAD) && (r_lv > aacu_pkg::CELL_GAS));

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_grid[mem_addr] <= wdata;
        end
        r_rdata <= r_grid[mem_addr];
    end

    // update decision; right neighbor is still in the read register
    assign right  = r_rdata;
    assign is_gas = (r_c == aacu_pkg::CELL_GAS);
    assign ice_hit = (r_nbr.lf_ok && r_l == aacu_pkg::CELL_ICE) ||
                     (r_nbr.rt_ok && right == aacu_pkg::CELL_ICE) ||
                     (r_nbr.dn_ok && r_d == aacu_pkg::CELL_ICE) ||
                     (r_nbr.up_ok && r_u == aacu_pkg::CELL_ICE);
    assign free_mask[aacu_pkg::DIR_UP]    = r_nbr.up_ok  && (r_u == aacu_pkg::CELL_EMPTY);
    assign free_mask[aacu_pkg::DIR_DOWN]  = r_nbr.dn_ok  && (r_d == aacu_pkg::CELL_EMPTY);
    assign free_mask[aacu_pkg::DIR_LEFT]  = r_nbr.lf2_ok && (r_l == aacu_pkg::CELL_EMPTY);
    assign free_mask[aacu_pkg::DIR_RIGHT] = r_nbr.rt2_ok && (right == aacu_pkg::CELL_EMPTY);
    assign free_cnt = 3'(free_mask[0]) + 3'(free_mask[1]) + 3'(free_mask[2])
                    + 3'(free_mask[3]);

    always_comb begin
        case (free_cnt)
            3'd2:    pick_idx = {1'b0, r_pick_lo[0]};
            3'd3:    pick_idx = r_pick_m3;
            3'd4:    pick_idx = r_pick_lo;
            default: pick_idx = 2'd0;
        endcase
    end

    assign dir = aacu_pkg::pick_dir(free_mask, pick_idx);

    always_comb begin
        o_stat.bad_addr  = r_nbr.bad;
        o_stat.is_load   = (r_kind == aacu_pkg::KIND_LOAD);
        o_stat.is_update = (r_kind == aacu_pkg::KIND_UPDATE);
        o_stat.freeze    = is_gas && ice_hit;
        o_stat.move      = is_gas && !ice_hit && (free_cnt != 3'd0);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_addr_c  <= AW'(row_w * DIM + col_w);
            r_nbr     <= in_nbr;
            r_kind    <= i_in.kind;
            r_lv      <= i_in.load_value;
            r_pick_lo <= i_in.random_pick[1:0];
            r_pick_m3 <= aacu_pkg::mod3_16(i_in.random_pick);
            r_res     <= '0;
        end else begin
            case (i_ctl.uw.cap)
                aacu_pkg::CAP_C: begin
                    r_c              <= r_rdata;
                    r_res.cell_state <= r_rdata;
                end
                aacu_pkg::CAP_U: r_u <= r_rdata;
                aacu_pkg::CAP_D: r_d <= r_rdata;
                aacu_pkg::CAP_L: r_l <= r_rdata;
                default: ;
            endcase
            if (i_ctl.uw.eval) begin
                if (o_stat.freeze) begin
                    r_res.cell_state <= aacu_pkg::CELL_ICE;
                    r_res.froze      <= 1'b1;
                end else if (o_stat.move) begin
                    r_res.cell_state <= aacu_pkg::CELL_EMPTY;
                    r_res.moved      <= 1'b1;
                    r_res.move_dir   <= dir;
                end
            end
        end
        if (i_ctl.out_load) begin
            r_out <= r_res;
        end
    end

    assign o_out = r_out;

endmodule

`default_nettype wire

/* hw/rtl/aggregation_automaton_cell_update_core.sv */
// ----------------------------------------------------------------------------
// aggregation_automaton_cell_update_core
// Cell store and in-place gas update for an aggregation automaton grid.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake               | word
//  --------+-----+-------------------------+-------------------------------
//  in      | in  | i_in_valid / o_in_ready | i_in  : kind,row,col,load,pick
//  out     | out | o_out_valid/i_out_ready | o_out : state,froze,moved,dir
//
//  The step sequence differs by kind: out-of-grid, read, load and update (no
//  change, freeze or move) each take their own path through the microprogram.
//  The grid memory is single-port: each of the five cell reads and two
//  writes of an update takes its own step in the microprogram.
//  Reset clears the step counter and output valid; the grid is not cleared.
//  One finished word waits in the output register; the next input is fetched
//  meanwhile, and only the emit step stalls while that register stays full.
// ----------------------------------------------------------------------------
`default_nettype none

module aggregation_automaton_cell_update_core #(
    parameter int GRID_DIM = 256
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_in_valid,
    output logic           o_in_ready,
    input  aacu_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  wire            i_out_ready,
    output aacu_pkg::t_out o_out
);

    aacu_pkg::t_dp_ctl  ctl;
    aacu_pkg::t_dp_stat stat;

    // microcoded control: step counter, ROM, handshakes
    aacu_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_ctl       (ctl)
    );

    // grid memory and update datapath
    aacu_dpath #(
        .GRID_DIM (GRID_DIM)
    ) u_dpath (
        .i_clk  (i_clk),
        .i_in   (i_in),
        .i_ctl  (ctl),
        .o_stat (stat),
        .o_out  (o_out)
    );

endmodule

`default_nettype wire

/* hw/rtl/aacu_checker.sv */
// ----------------------------------------------------------------------------
// aacu_checker
// Port-level checks of the cell update core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "aggregation_automaton_cell_update_core_macros.svh"

module aacu_checker (
    input wire            i_clk,
    input wire            i_rst_n,
    input wire            i_in_valid,
    input wire            o_in_ready,
    input wire            o_out_valid,
    input wire            i_out_ready,
    input aacu_pkg::t_out o_out
);

    // an update either freezes or moves, never both
    `AACU_ASSERT_IMP(a_frz_mv_excl, i_clk, i_rst_n, o_out_valid, !(o_out.froze && o_out.moved))

    // direction reads zero unless the gas moved
    `AACU_ASSERT_IMP(a_dir_idle, i_clk, i_rst_n, o_out_valid && !o_out.moved, o_out.move_dir == aacu_pkg::DIR_UP)

    // frozen cell reports ice, vacated cell reports empty
    `AACU_ASSERT_IMP(a_state_match, i_clk, i_rst_n, o_out_valid, (!o_out.froze || o_out.cell_state == aacu_pkg::CELL_ICE) && (!o_out.moved || o_out.cell_state == aacu_pkg::CELL_EMPTY))

    // one word in flight: input closes right after an accept
    `AACU_ASSERT_NXT(a_one_item, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

    // stalled output word holds
    `AACU_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out))

endmodule

bind aggregation_automaton_cell_update_core aacu_checker u_aacu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);

`default_nettype wire
